// ===== hw/rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared types for the polygon separating-axis collision block
// Vertex word layout, normal and projection widths, span record.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int CoordW = 16;
    localparam int NormW  = CoordW + 1;        // edge difference
    localparam int ProdW  = CoordW + NormW;    // one coordinate product
    localparam int DotW   = ProdW + 1;         // sum of two products

    typedef struct packed {
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] x;
    } vertex_t;

    typedef struct packed {
        logic signed [DotW-1:0] lo1;
        logic signed [DotW-1:0] hi1;
        logic signed [DotW-1:0] lo2;
        logic signed [DotW-1:0] hi2;
    } span_t;

endpackage

// ===== hw/rtl/psc_cell.sv =====
// ----------------------------------------------------------------------------
// psc_cell: one vertex cell of a rotating vertex ring
// Holds one vertex; loads from the input word or takes its neighbor's vertex.
// ----------------------------------------------------------------------------
module psc_cell (
    input  logic            clk,
    input  logic            load_en,
    input  psc_pkg::vertex_t load_vtx,
    input  logic            shift_en,
    input  psc_pkg::vertex_t shift_in,
    output psc_pkg::vertex_t vtx
);
    import psc_pkg::*;

    vertex_t vtx_reg;

    // load has priority; shifting never overlaps a load
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            vtx_reg <= load_vtx;
        end
        else if (shift_en)
        begin
            vtx_reg <= shift_in;
        end
    end

    assign vtx = vtx_reg;

endmodule

// ===== hw/rtl/psc_ring.sv =====
// ----------------------------------------------------------------------------
// psc_ring: chain of vertex cells that rotates over the stored vertices
// Cell i takes cell i+1; the last stored cell wraps to cell 0.
// ----------------------------------------------------------------------------
module psc_ring #(
    parameter int N = 16
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(N)-1:0]      wr_idx,
    input  psc_pkg::vertex_t          wr_vtx,
    input  logic                      shift_en,
    input  logic [$clog2(N+1)-1:0]    count,
    output psc_pkg::vertex_t          head,
    output psc_pkg::vertex_t          second
);
    import psc_pkg::*;

    localparam int CW = $clog2(N+1);
    localparam int IW = $clog2(N);

    vertex_t cells [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            vertex_t nb;
            // wrap at the last occupied cell
            assign nb = ((CW'(i) + CW'(1)) == count) ? cells[0] : cells[(i+1) % N];
            psc_cell u_cell (
                .clk      (clk),
                .load_en  (wr_en && (wr_idx == IW'(i))),
                .load_vtx (wr_vtx),
                .shift_en (shift_en),
                .shift_in (nb),
                .vtx      (cells[i])
            );
        end
    endgenerate

    assign head   = cells[0];
    // single vertex: the edge closes on itself
    assign second = (count < CW'(2)) ? cells[0] : cells[1];

endmodule

// ===== hw/rtl/psc_proj.sv =====
// ----------------------------------------------------------------------------
// psc_proj: projection and span unit
// Registered products, then dot sum and running min/max for both polygons.
// ----------------------------------------------------------------------------
module psc_proj (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  psc_pkg::vertex_t              v1,
    input  logic                          v1_ok,
    input  psc_pkg::vertex_t              v2,
    input  logic                          v2_ok,
    input  logic signed [psc_pkg::NormW-1:0] nx,
    input  logic signed [psc_pkg::NormW-1:0] ny,
    output psc_pkg::span_t                span
);
    import psc_pkg::*;

    logic signed [ProdW-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic                    ok1_reg, ok2_reg;
    logic                    have1_reg, have2_reg;
    span_t                   span_reg, span_next;
    logic signed [DotW-1:0]  d1, d2;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        p1x_reg <= v1.x * nx;
        p1y_reg <= v1.y * ny;
        p2x_reg <= v2.x * nx;
        p2y_reg <= v2.y * ny;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok1_reg <= 1'b0;
            ok2_reg <= 1'b0;
        end
        else
        begin
            ok1_reg <= v1_ok && !clear;
            ok2_reg <= v2_ok && !clear;
        end
    end

    // stage 2: dot sum and min/max update
    assign d1 = DotW'(p1x_reg) + DotW'(p1y_reg);
    assign d2 = DotW'(p2x_reg) + DotW'(p2y_reg);

    always_comb
    begin
        span_next = span_reg;
        if (ok1_reg)
        begin
            if (!have1_reg || d1 < span_reg.lo1) span_next.lo1 = d1;
            if (!have1_reg || d1 > span_reg.hi1) span_next.hi1 = d1;
        end
        if (ok2_reg)
        begin
            if (!have2_reg || d2 < span_reg.lo2) span_next.lo2 = d2;
            if (!have2_reg || d2 > span_reg.hi2) span_next.hi2 = d2;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end
        else if (clear)
        begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end
        else
        begin
            have1_reg <= have1_reg || ok1_reg;
            have2_reg <= have2_reg || ok2_reg;
        end
    end

    assign span = span_reg;

endmodule

// ===== hw/rtl/polygon_sat_collision.sv =====
// ----------------------------------------------------------------------------
// polygon_sat_collision: separating-axis collision test of two convex polygons
//
//   channel  dir  handshake            fields
//   in       in   in_valid/in_ready    mode, vertex_x, vertex_y, last_vertex
//   out      out  out_valid/out_ready  collide
//
// Vertex words are taken only while idle. The word that closes the second
// polygon starts a test: each axis is one full rotation of both vertex
// rings through the shared projection unit. No input is taken during a
// test. Reset clears counts and control; a result waits in the output
// register while new vertex words are taken.
// ----------------------------------------------------------------------------
module polygon_sat_collision #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic signed [15:0]  vertex_x,
    input  logic signed [15:0]  vertex_y,
    input  logic                last_vertex,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                collide
);
    import psc_pkg::*;

    localparam int N  = MAX_VERTICES;
    localparam int CW = $clog2(N+1);
    localparam int IW = $clog2(N);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_AXIS  = 7'b0000100,
        S_SWEEP = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    logic [CW-1:0] n1_reg, n1_next, n2_reg, n2_next;
    logic [CW-1:0] sc_reg, sc_next, ec_reg, ec_next;
    logic    src_reg, src_next;
    logic    res_reg, res_next;
    logic    out_valid_reg, out_valid_next;
    logic    collide_reg, collide_next;
    logic signed [NormW-1:0] nx_reg, nx_next, ny_reg, ny_next;

    logic    acc, wr1, wr2, sh1, sh2, ok1, ok2, sep, clear;
    logic [CW-1:0] len, nsrc;
    vertex_t in_vtx, h1, s1, h2, s2, ha, sa;
    span_t   span;

    assign in_vtx.x = vertex_x;
    assign in_vtx.y = vertex_y;
    assign acc      = in_valid && in_ready;
    assign wr1      = acc && !mode && (n1_reg < CW'(N));
    assign wr2      = acc && mode && (n2_reg < CW'(N));

    assign len  = (n1_reg > n2_reg) ? n1_reg : n2_reg;
    assign nsrc = src_reg ? n2_reg : n1_reg;
    assign ha   = src_reg ? h2 : h1;
    assign sa   = src_reg ? s2 : s1;

    assign ok1   = (state_reg == S_SWEEP) && (sc_reg < n1_reg);
    assign ok2   = (state_reg == S_SWEEP) && (sc_reg < n2_reg);
    assign sep   = (span.hi1 < span.lo2) || (span.lo1 > span.hi2);
    assign clear = (state_reg == S_AXIS);
    // step the edge ring by one after an axis that did not separate
    assign sh1 = ok1 || ((state_reg == S_CHECK) && !sep && !src_reg);
    assign sh2 = ok2 || ((state_reg == S_CHECK) && !sep && src_reg);

    psc_ring #(.N(N)) u_ring1 (
        .clk(clk), .wr_en(wr1), .wr_idx(n1_reg[IW-1:0]), .wr_vtx(in_vtx),
        .shift_en(sh1), .count(n1_reg), .head(h1), .second(s1)
    );

    psc_ring #(.N(N)) u_ring2 (
        .clk(clk), .wr_en(wr2), .wr_idx(n2_reg[IW-1:0]), .wr_vtx(in_vtx),
        .shift_en(sh2), .count(n2_reg), .head(h2), .second(s2)
    );

    psc_proj u_proj (
        .clk(clk), .rst_n(rst_n), .clear(clear),
        .v1(h1), .v1_ok(ok1), .v2(h2), .v2_ok(ok2),
        .nx(nx_reg), .ny(ny_reg), .span(span)
    );

    assign in_ready = (state_reg == S_IDLE);

    // test sequencer
    always_comb
    begin
        state_next     = state_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        sc_next        = sc_reg;
        ec_next        = ec_reg;
        src_next       = src_reg;
        res_next       = res_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        out_valid_next = out_valid_reg && !out_ready;
        collide_next   = collide_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (wr1) n1_next = n1_reg + CW'(1);
                if (wr2) n2_next = n2_reg + CW'(1);
                if (acc && mode && last_vertex) state_next = S_START;
            end
            S_START:
            begin
                src_next = 1'b0;
                ec_next  = '0;
                if (n1_reg == '0 || n2_reg == '0)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                nx_next    = NormW'(ha.y) - NormW'(sa.y);
                ny_next    = NormW'(sa.x) - NormW'(ha.x);
                sc_next    = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                sc_next = sc_reg + CW'(1);
                if (sc_reg == len - CW'(1)) state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sep)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (ec_reg == nsrc - CW'(1))
                begin
                    ec_next = '0;
                    if (src_reg)
                    begin
                        res_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        src_next   = 1'b1;
                        state_next = S_AXIS;
                    end
                end
                else
                begin
                    ec_next    = ec_reg + CW'(1);
                    state_next = S_AXIS;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    collide_next   = res_reg;
                    n1_next        = '0;
                    n2_next        = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n1_reg        <= '0;
            n2_reg        <= '0;
            sc_reg        <= '0;
            ec_reg        <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n1_reg        <= n1_next;
            n2_reg        <= n2_next;
            sc_reg        <= sc_next;
            ec_reg        <= ec_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        collide_reg <= collide_next;
    end

    assign out_valid = out_valid_reg;
    assign collide   = collide_reg;

endmodule

// ===== bench/polygon_sat_collision_checker.sv =====
// ----------------------------------------------------------------------------
// polygon_sat_collision_checker: collision predictor and result scoreboard
// Watches both channels, rebuilds the two vertex rings from accepted words,
// predicts the collide bit of each closing word, and compares it in order.
// ----------------------------------------------------------------------------
module polygon_sat_collision_checker #(
    parameter int MAX_VERTICES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               mode,
    input  logic signed [15:0] vertex_x,
    input  logic signed [15:0] vertex_y,
    input  logic               last_vertex,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               collide,
    output int                 errors,
    output int                 pending,
    output int                 tests_seen,
    output int                 hits_seen
);
    import psc_pkg::*;

    vertex_t ring_a [MAX_VERTICES];
    vertex_t ring_b [MAX_VERTICES];
    int      count_a;
    int      count_b;
    bit      collide_q [$];

    // min/max of one ring projected onto (nx, ny)
    function automatic void project_ring(input bit use_b, input longint nx,
                                         input longint ny, output longint lo,
                                         output longint hi);
        longint d;
        int     n;
        vertex_t v;
        n  = use_b ? count_b : count_a;
        lo = 0;
        hi = 0;
        for (int i = 0; i < n; i++)
        begin
            v = use_b ? ring_b[i] : ring_a[i];
            d = longint'(v.x) * nx + longint'(v.y) * ny;
            if (i == 0 || d < lo) lo = d;
            if (i == 0 || d > hi) hi = d;
        end
    endfunction

    // true if an edge normal of the chosen ring splits the two rings
    function automatic bit axis_splits(input bit use_b);
        int      n;
        vertex_t a;
        vertex_t b;
        longint  nx;
        longint  ny;
        longint  lo1, hi1, lo2, hi2;
        n = use_b ? count_b : count_a;
        for (int e = 0; e < n; e++)
        begin
            a  = use_b ? ring_b[e] : ring_a[e];
            b  = use_b ? ring_b[(e + 1) % n] : ring_a[(e + 1) % n];
            nx = -(longint'(b.y) - longint'(a.y));
            ny = longint'(b.x) - longint'(a.x);
            project_ring(1'b0, nx, ny, lo1, hi1);
            project_ring(1'b1, nx, ny, lo2, hi2);
            if (hi1 < lo2 || lo1 > hi2) return 1'b1;
        end
        return 1'b0;
    endfunction

    assign pending = collide_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a    = 0;
            count_b    = 0;
            errors     = 0;
            tests_seen = 0;
            hits_seen  = 0;
            collide_q.delete();
        end
        else
        begin
            // result word: compare with oldest prediction
            if (out_valid && out_ready)
            begin
                tests_seen++;
                if (collide) hits_seen++;
                if (collide_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, collide=%0b", $time, collide);
                    errors++;
                end
                else
                begin
                    if (collide !== collide_q[0])
                    begin
                        $display("%0t: collide mismatch, expected %0b actual %0b",
                                 $time, collide_q[0], collide);
                        errors++;
                    end
                    void'(collide_q.pop_front());
                end
            end
            // vertex word: store, and on closing word predict
            if (in_valid && in_ready)
            begin
                if (!mode)
                begin
                    if (count_a < MAX_VERTICES) ring_a[count_a++] = {vertex_y, vertex_x};
                end
                else
                begin
                    if (count_b < MAX_VERTICES) ring_b[count_b++] = {vertex_y, vertex_x};
                    if (last_vertex)
                    begin
                        if (count_a == 0 || count_b == 0)
                            collide_q.push_back(1'b0);
                        else
                            collide_q.push_back(!axis_splits(1'b0) && !axis_splits(1'b1));
                        count_a = 0;
                        count_b = 0;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/polygon_sat_collision_tb.sv =====
// ----------------------------------------------------------------------------
// polygon_sat_collision_tb: stimulus and verdict for the collision block
// Directed polygon pairs (extremes, touching, empty, degenerate, overflow),
// then random convex and noisy pairs under bursty input and stalled output.
// ----------------------------------------------------------------------------
module polygon_sat_collision_tb;
    localparam int MaxVerts = 16;
    localparam int CycleLimit = 2000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               last_vertex;
    logic               out_valid;
    logic               out_ready;
    logic               collide;
    int                 errors;
    int                 pending;
    int                 tests_seen;
    int                 hits_seen;
    int                 cycles;
    int                 words_sent;
    int                 burst_left;

    polygon_sat_collision #(.MAX_VERTICES(MaxVerts)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .vertex_x(vertex_x), .vertex_y(vertex_y),
        .last_vertex(last_vertex), .out_valid(out_valid), .out_ready(out_ready),
        .collide(collide)
    );

    polygon_sat_collision_checker #(.MAX_VERTICES(MaxVerts)) i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .vertex_x(vertex_x), .vertex_y(vertex_y),
        .last_vertex(last_vertex), .out_valid(out_valid), .out_ready(out_ready),
        .collide(collide), .errors(errors), .pending(pending),
        .tests_seen(tests_seen), .hits_seen(hits_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls: alternating phases of steady and patchy ready
    always @(negedge clk)
    begin
        int phase;
        phase = (cycles / 300) % 3;
        if (phase == 0)      out_ready <= 1'b1;
        else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else                 out_ready <= ($urandom_range(0, 3) == 0);
    end

    // send one vertex word; gaps come between bursts, valid holds inside one
    task automatic send_vertex(input bit m, input int x, input int y, input bit lst);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        mode        <= m;
        vertex_x    <= 16'(x);
        vertex_y    <= 16'(y);
        last_vertex <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic int rand_coord(input int span_mag);
        return $urandom_range(0, 2 * span_mag) - span_mag;
    endfunction

    // regular-ish convex polygon around (cx, cy), counter-clockwise
    task automatic send_convex(input bit m, input int n, input int cx, input int cy,
                               input int r, input bit close_it);
        real ang;
        int  x;
        int  y;
        for (int i = 0; i < n; i++)
        begin
            ang = 6.283185307 * i / n;
            x = cx + $rtoi(r * $cos(ang));
            y = cy + $rtoi(r * $sin(ang));
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            send_vertex(m, x, y, close_it && (i == n - 1));
        end
    endtask

    task automatic send_box(input bit m, input int x0, input int y0,
                            input int x1, input int y1);
        send_vertex(m, x0, y0, 1'b0);
        send_vertex(m, x1, y0, 1'b0);
        send_vertex(m, x1, y1, 1'b0);
        send_vertex(m, x0, y1, 1'b1);
    endtask

    initial
    begin
        int kind;
        int r;
        int d;
        words_sent  = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = 1'b0;
        vertex_x    = '0;
        vertex_y    = '0;
        last_vertex = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: overlapping, touching, separated boxes
        send_box(1'b0, 0, 0, 10, 10);
        send_box(1'b1, 5, 5, 20, 20);
        send_box(1'b0, 0, 0, 10, 10);
        send_box(1'b1, 10, 0, 20, 10);
        send_box(1'b0, -32768, -32768, 32767, 32767);
        send_box(1'b1, 32767, 32767, -32768, -32768);
        send_box(1'b0, -32768, -32768, -32000, -32000);
        send_box(1'b1, 32000, 32000, 32767, 32767);
        // empty first polygon
        send_vertex(1'b1, 1, 2, 1'b1);
        // single points and a segment, repeated vertices
        send_vertex(1'b0, 3, 3, 1'b1);
        send_vertex(1'b1, 3, 3, 1'b1);
        send_vertex(1'b0, 0, 0, 1'b0);
        send_vertex(1'b0, 0, 0, 1'b1);
        send_vertex(1'b1, -5, 7, 1'b0);
        send_vertex(1'b1, 9, -1, 1'b1);
        // overflowing stores, overflowing closing word still tests
        send_convex(1'b0, MaxVerts + 3, 0, 0, 1000, 1'b1);
        send_convex(1'b1, MaxVerts + 2, 500, 0, 1000, 1'b1);

        // random pairs
        while (words_sent < 850)
        begin
            kind = $urandom_range(0, 9);
            r    = $urandom_range(1, 12000);
            d    = $urandom_range(0, 3 * r);
            if (kind < 7)
            begin
                send_convex(1'b0, $urandom_range(3, 8), rand_coord(8000), rand_coord(8000),
                            r, 1'b1);
                send_convex(1'b1, $urandom_range(3, 8), rand_coord(8000), rand_coord(8000),
                            $urandom_range(1, 12000), 1'b1);
            end
            else if (kind == 7)
            begin
                send_convex(1'b0, $urandom_range(3, 6), 0, 0, r, 1'b1);
                send_convex(1'b1, $urandom_range(3, 6), d, 0, r, 1'b1);
            end
            else
            begin
                // noise: raw random words of any content
                repeat ($urandom_range(1, 6))
                    send_vertex($urandom_range(0, 1), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 1));
                send_vertex(1'b1, rand_coord(32768), rand_coord(32767), 1'b1);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        $display("Sent %0d vertex words; %0d tests checked, %0d of them collisions.",
                 words_sent, tests_seen, hits_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
